// ===== hw/rtl/tccw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants for the text console character writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

    // default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // word field widths
    localparam int KIND_W   = 2;
    localparam int CHAR_W   = 8;
    localparam int CELL_W   = 11;
    localparam int CURSOR_W = 11;
    localparam int COL_OUT_W = 7;
    localparam int ROW_OUT_W = 5;
    localparam int ATTR_W   = 8;

    // packed stream widths
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 40;

    // character and attribute codes
    localparam logic [CHAR_W-1:0] NEWLINE    = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE      = 8'h20;
    localparam logic [ATTR_W-1:0] CLEAR_ATTR = 8'h0F;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // cell store word: attribute high, character low
    localparam int CELL_DATA_W = ATTR_W + CHAR_W;

    // word kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_PUT   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2
    } kind_t;

    // sequencer states
    typedef enum logic [8:0] {
        ST_INIT      = 9'b000000001,
        ST_IDLE      = 9'b000000010,
        ST_EXEC      = 9'b000000100,
        ST_SCROLL_RD = 9'b000001000,
        ST_SCROLL_WR = 9'b000010000,
        ST_FILL      = 9'b000100000,
        ST_WRITE     = 9'b001000000,
        ST_READ_WAIT = 9'b010000000,
        ST_RESP      = 9'b100000000
    } state_t;

endpackage

// ===== hw/rtl/tccw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tccw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/text_console_char_writer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer_core
// Text-mode console writer over a ROWS x COLUMNS store of character cells.
// ----------------------------------------------------------------------------
// One word is taken at a time and gives one result word. A printed character
// passes through EXEC, WRITE and RESP; a newline, an unused kind or an
// out-of-range read through EXEC and RESP; any other read through EXEC,
// READ_WAIT and RESP. RESP waits while a result word is still stalled. A
// scroll adds alternating SCROLL_RD and SCROLL_WR states and a FILL of the last
// row, a clear a FILL of every cell: every cell goes through the single write
// port of the cell RAM, and a scroll copy also needs one read per cell. After
// reset the block zeroes all ROWS*COLUMNS cells (2000 by default) with s_tready
// low; the attribute register can be written at any time.
module text_console_char_writer_core
    #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // attribute register
    input  logic                          cfg_we,
    input  logic [tccw_pkg::ATTR_W-1:0]   cfg_wdata,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tccw_pkg::S_DATA_W-1:0] s_tdata,   // char_code[7:0], cell_index[18:8]
    input  logic [tccw_pkg::KIND_W-1:0]   s_tuser,   // kind[1:0]
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tccw_pkg::M_DATA_W-1:0] m_tdata    // cursor_pos[10:0], cur_column[17:11],
                                                     // cur_row[22:18], cell_char[30:23],
                                                     // cell_attr[38:31]
);

    import tccw_pkg::*;

    localparam int CELLS     = ROWS * COLUMNS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int CNT_W     = $clog2(CELLS + 1);
    localparam int COL_W     = $clog2(COLUMNS + 1);
    localparam int ROW_W     = $clog2(ROWS + 1);
    localparam int LAST_BASE = (ROWS - 1) * COLUMNS;
    localparam int COPY_LAST = LAST_BASE - 1;

    // control and position state
    state_t                state_reg, state_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [CNT_W-1:0]      base_reg, base_next;
    logic [CNT_W-1:0]      cursor_reg, cursor_next;
    logic [ATTR_W-1:0]     attr_reg;
    logic                  m_valid_reg, m_valid_next;

    // payload registers
    kind_t                 kind_reg, kind_next;
    logic [CHAR_W-1:0]     char_reg, char_next;
    logic [CELL_W-1:0]     cell_reg, cell_next;
    logic [ADDR_W-1:0]     ptr_reg, ptr_next;
    logic [CELL_DATA_W-1:0] fill_reg, fill_next;
    logic [CHAR_W-1:0]     rc_reg, rc_next;
    logic [ATTR_W-1:0]     ra_reg, ra_next;
    logic [M_DATA_W-1:0]   m_data_reg, m_data_next;

    // cell RAM port
    logic                   ram_we, ram_re;
    logic [ADDR_W-1:0]      ram_waddr, ram_raddr;
    logic [CELL_DATA_W-1:0] ram_wdata, ram_rdata;

    // shared sweep unit and position helpers
    logic [ADDR_W-1:0]  ptr_inc, ptr_src;
    logic               wrap;
    logic [ROW_W-1:0]   row_wrap;
    logic [CNT_W-1:0]   base_wrap;
    logic [CNT_W-1:0]   wr_pos;
    logic [31:0]        cursor_w, col_w, row_w;

    tccw_ram #(
        .WIDTH (CELL_DATA_W),
        .DEPTH (CELLS)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sweep pointer step and scroll source address
    assign ptr_inc = ptr_reg + ADDR_W'(1);
    assign ptr_src = ptr_reg + ADDR_W'(COLUMNS);

    // newline or column past the end moves to the next row, row saturates
    assign wrap      = (char_reg == NEWLINE) || (col_reg > COL_W'(COLUMNS - 1));
    assign row_wrap  = (row_reg < ROW_W'(ROWS)) ? row_reg + ROW_W'(1) : row_reg;
    assign base_wrap = (row_reg < ROW_W'(ROWS)) ? base_reg + CNT_W'(COLUMNS) : base_reg;
    assign wr_pos    = base_reg + CNT_W'(col_reg);

    // result fields widened to 32 bits, cut to their port widths in the result word
    assign cursor_w = 32'(cursor_reg);
    assign col_w    = 32'(col_reg);
    assign row_w    = 32'(row_reg);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        base_next    = base_reg;
        cursor_next  = cursor_reg;
        kind_next    = kind_reg;
        char_next    = char_reg;
        cell_next    = cell_reg;
        ptr_next     = ptr_reg;
        fill_next    = fill_reg;
        rc_next      = rc_reg;
        ra_next      = ra_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        ram_we       = 1'b0;
        ram_waddr    = ptr_reg;
        ram_wdata    = fill_reg;
        ram_re       = 1'b0;
        ram_raddr    = ptr_src;

        unique case (state_reg)
            ST_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                ptr_next  = ptr_inc;
                if (ptr_reg == ADDR_W'(CELLS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    kind_next  = kind_t'(s_tuser);
                    char_next  = s_tdata[CHAR_W-1:0];
                    cell_next  = s_tdata[CHAR_W +: CELL_W];
                    rc_next    = '0;
                    ra_next    = '0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (kind_reg)
                    KIND_PUT: begin
                        if (wrap) begin
                            col_next  = '0;
                            row_next  = row_wrap;
                            base_next = base_wrap;
                        end
                        if (char_reg == NEWLINE) begin
                            state_next = ST_RESP;
                        end else if (wrap && row_wrap == ROW_W'(ROWS)
                                     || !wrap && row_reg == ROW_W'(ROWS)) begin
                            // scroll pending: copy rows up, then blank the last row
                            row_next   = ROW_W'(ROWS - 1);
                            base_next  = CNT_W'(LAST_BASE);
                            ptr_next   = '0;
                            state_next = ST_SCROLL_RD;
                        end else begin
                            state_next = ST_WRITE;
                        end
                    end
                    KIND_CLEAR: begin
                        fill_next  = {CLEAR_ATTR, SPACE};
                        ptr_next   = '0;
                        col_next   = '0;
                        row_next   = '0;
                        base_next  = '0;
                        state_next = ST_FILL;
                    end
                    KIND_READ: begin
                        if (32'(cell_reg) < 32'(CELLS)) begin
                            ram_re     = 1'b1;
                            ram_raddr  = ADDR_W'(cell_reg);
                            state_next = ST_READ_WAIT;
                        end else begin
                            state_next = ST_RESP;
                        end
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_SCROLL_RD: begin
                ram_re     = 1'b1;
                state_next = ST_SCROLL_WR;
            end
            ST_SCROLL_WR: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata;
                ptr_next  = ptr_inc;
                if (ptr_reg == ADDR_W'(COPY_LAST)) begin
                    fill_next  = '0;
                    state_next = ST_FILL;
                end else begin
                    state_next = ST_SCROLL_RD;
                end
            end
            ST_FILL: begin
                ram_we   = 1'b1;
                ptr_next = ptr_inc;
                if (ptr_reg == ADDR_W'(CELLS - 1)) begin
                    state_next = (kind_reg == KIND_PUT) ? ST_WRITE : ST_RESP;
                end
            end
            ST_WRITE: begin
                // store the character and move the cursor past it
                ram_we      = 1'b1;
                ram_waddr   = ADDR_W'(wr_pos);
                ram_wdata   = {attr_reg, char_reg};
                col_next    = col_reg + COL_W'(1);
                cursor_next = wr_pos + CNT_W'(1);
                state_next  = ST_RESP;
            end
            ST_READ_WAIT: begin
                rc_next    = ram_rdata[CHAR_W-1:0];
                ra_next    = ram_rdata[CHAR_W +: ATTR_W];
                state_next = ST_RESP;
            end
            ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = {1'b0, ra_reg, rc_reg, row_w[ROW_OUT_W-1:0],
                                    col_w[COL_OUT_W-1:0], cursor_w[CURSOR_W-1:0]};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            col_reg     <= '0;
            row_reg     <= '0;
            base_reg    <= '0;
            cursor_reg  <= '0;
            m_valid_reg <= 1'b0;
            ptr_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            base_reg    <= base_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
            ptr_reg     <= ptr_next;
        end
    end

    // attribute register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else if (cfg_we) begin
            attr_reg <= cfg_wdata;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        char_reg   <= char_next;
        cell_reg   <= cell_next;
        fill_reg   <= fill_next;
        rc_reg     <= rc_next;
        ra_reg     <= ra_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== hw/rtl/tccw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_checker
// Port-level checks for the text console character writer, bound to the core.
// ----------------------------------------------------------------------------
module tccw_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tccw_pkg::M_DATA_W-1:0] m_tdata
);

    // cell RAM is being zeroed right after reset
    a_busy_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready right after reset");

    // one word at a time: busy in the cycle after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after accept");

    // a new result only comes out of a busy cycle
    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work");

    // stalled result word holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

endmodule

bind text_console_char_writer_core tccw_checker u_tccw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: text console character writer testbench
// Drives put, clear, read and unused words into the console writer, mirrors
// the cell store, write position and cursor register in a behavioral model,
// and compares every result word field by field. A short table of directed
// words comes first, then random text, newlines, reads and clears under
// several attribute settings, with random gaps on both streams and one long
// receiver stall.
// ----------------------------------------------------------------------------
module tb_top;
    import tccw_pkg::*;

    localparam int COLS    = COLUMNS_DEF;
    localparam int ROWS_N  = ROWS_DEF;
    localparam int CELLS   = COLS * ROWS_N;
    localparam int MAX_GAP = 8;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AT_WORD = 400;
    localparam int TAIL_CYCLES  = 50;
    // every word scrolling, both sides at their longest gap, several times over
    localparam longint CYCLE_LIMIT = 15_000_000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // result word, first field in the highest bits
    typedef struct packed {
        logic [ATTR_W-1:0]    cell_attr;
        logic [CHAR_W-1:0]    cell_char;
        logic [ROW_OUT_W-1:0] cur_row;
        logic [COL_OUT_W-1:0] cur_column;
        logic [CURSOR_W-1:0]  cursor_pos;
    } console_word_t;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] ch;
        logic [CELL_W-1:0] cell_idx;
        int                reps;
        bit                typed;
        console_word_t     want;
    } stim_row_t;

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [ATTR_W-1:0]   cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [KIND_W-1:0]   s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;

    // mirror of the console state
    logic [CELL_DATA_W-1:0] screen_mirror [CELLS];
    int                     wr_col;
    int                     wr_row;
    int                     cursor_mirror;
    logic [ATTR_W-1:0]      attr_mirror;

    console_word_t expected_words [$];
    stim_row_t     stim_rows [$];
    console_word_t want_word;
    console_word_t got_word;
    int            mismatches;
    bit            quiet_stretch;
    longint        cycle_count;

    text_console_char_writer_core #(
        .COLUMNS(COLS),
        .ROWS   (ROWS_N)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // next console state and result word for one accepted word
    function automatic console_word_t predict_console_word(logic [KIND_W-1:0] kind,
                                                           logic [CHAR_W-1:0] ch,
                                                           logic [CELL_W-1:0] cell_idx);
        console_word_t w;
        int i;
        int idx;
        w = '0;
        if (kind == KIND_PUT) begin
            // newline or a full row moves to the next row, saturating one past the last
            if (ch == NEWLINE || wr_col > COLS - 1) begin
                wr_col = 0;
                if (wr_row < ROWS_N) wr_row++;
            end
            if (ch != NEWLINE) begin
                // pending scroll: move everything up one row, blank the bottom
                if (wr_row > ROWS_N - 1) begin
                    for (i = 0; i < CELLS - COLS; i++) screen_mirror[i] = screen_mirror[i + COLS];
                    for (i = CELLS - COLS; i < CELLS; i++) screen_mirror[i] = '0;
                    wr_row = ROWS_N - 1;
                end
                idx = wr_row * COLS + wr_col;
                if (idx < CELLS) screen_mirror[idx] = {attr_mirror, ch};
                wr_col++;
                cursor_mirror = wr_row * COLS + wr_col;
            end
        end else if (kind == KIND_CLEAR) begin
            for (i = 0; i < CELLS; i++) screen_mirror[i] = {CLEAR_ATTR, SPACE};
            wr_col = 0;
            wr_row = 0;
        end else if (kind == KIND_READ) begin
            if (cell_idx < CELLS) begin
                w.cell_char = screen_mirror[cell_idx][CHAR_W-1:0];
                w.cell_attr = screen_mirror[cell_idx][CELL_DATA_W-1:CHAR_W];
            end
        end
        w.cursor_pos = cursor_mirror[CURSOR_W-1:0];
        w.cur_column = wr_col[COL_OUT_W-1:0];
        w.cur_row    = wr_row[ROW_OUT_W-1:0];
        return w;
    endfunction

    // offer one word after a random gap; called and returns at a falling edge
    task automatic send_word(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch,
                             logic [CELL_W-1:0] cell_idx, bit typed, console_word_t want);
        int gap;
        console_word_t predicted;
        gap = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {{(S_DATA_W - CELL_W - CHAR_W){1'b0}}, cell_idx, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = predict_console_word(kind, ch, cell_idx);
        expected_words.push_back(typed ? want : predicted);
        @(negedge aclk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_attribute(logic [ATTR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we      <= 1'b0;
        attr_mirror = value;
    endtask

    task automatic add_row(logic [KIND_W-1:0] kind, logic [CHAR_W-1:0] ch,
                           logic [CELL_W-1:0] cell_idx, int reps, bit typed,
                           int cursor, int col, int row, int chr, int attr);
        stim_row_t r;
        r.kind     = kind;
        r.ch       = ch;
        r.cell_idx = cell_idx;
        r.reps     = reps;
        r.typed    = typed;
        r.want.cursor_pos = cursor[CURSOR_W-1:0];
        r.want.cur_column = col[COL_OUT_W-1:0];
        r.want.cur_row    = row[ROW_OUT_W-1:0];
        r.want.cell_char  = chr[CHAR_W-1:0];
        r.want.cell_attr  = attr[ATTR_W-1:0];
        stim_rows.push_back(r);
    endtask

    // random text with newlines, reads near the cursor and anywhere, rare clears
    task automatic run_random(int count);
        int n;
        int r;
        int last;
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] ch;
        logic [CELL_W-1:0] cell_idx;
        for (n = 0; n < count; n++) begin
            if (n % 40 == 0) quiet_stretch = ($urandom_range(0, 3) == 0);
            r        = $urandom_range(0, 999);
            ch       = CHAR_W'($urandom_range(0, 255));
            cell_idx = CELL_W'($urandom_range(0, 2047));
            if (r < 5) begin
                kind = KIND_CLEAR;
            end else if (r < 35) begin
                kind = KIND_UNUSED;
            end else if (r < 215) begin
                kind = KIND_READ;
                r    = $urandom_range(0, 9);
                last = wr_row * COLS + wr_col - 1;
                if (r < 5 && last >= 0 && last < CELLS) cell_idx = CELL_W'(last);
                else if (r < 8) cell_idx = CELL_W'($urandom_range(0, CELLS - 1));
            end else begin
                kind = KIND_PUT;
                if ($urandom_range(0, 11) == 0) ch = NEWLINE;
            end
            send_word(kind, ch, cell_idx, 1'b0, '0);
        end
        quiet_stretch = 1'b0;
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $error("result word with nothing expected: %h", m_tdata);
                mismatches++;
            end else begin
                want_word = expected_words.pop_front();
                got_word  = m_tdata[$bits(console_word_t)-1:0];
                check_field("cursor_pos", want_word.cursor_pos, got_word.cursor_pos);
                check_field("cur_column", want_word.cur_column, got_word.cur_column);
                check_field("cur_row",    want_word.cur_row,    got_word.cur_row);
                check_field("cell_char",  want_word.cell_char,  got_word.cell_char);
                check_field("cell_attr",  want_word.cell_attr,  got_word.cell_attr);
            end
        end
    end

    // result receiver with random stalls and one long hold-off
    initial begin
        int stall;
        int taken;
        m_tready = 1'b0;
        taken    = 0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = quiet_stretch ? 0 : $urandom_range(0, MAX_GAP);
            if (taken == HOLD_AT_WORD) stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            taken++;
            @(negedge aclk);
        end
    end

    // main sequence
    initial begin
        int i;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        quiet_stretch = 1'b0;
        mismatches    = 0;
        for (i = 0; i < CELLS; i++) screen_mirror[i] = '0;
        wr_col        = 0;
        wr_row        = 0;
        cursor_mirror = 0;
        attr_mirror   = ATTR_RESET;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed words: reset contents, extremes, newline, clear, wrap, scroll
        add_row(KIND_READ,   8'h00,   11'd0,    1, 1'b1, 0, 0, 0, 8'h00, 8'h00);
        add_row(KIND_READ,   8'h00,   11'd1999, 1, 1'b1, 0, 0, 0, 8'h00, 8'h00);
        add_row(KIND_READ,   8'hFF,   11'h7FF,  1, 1'b1, 0, 0, 0, 8'h00, 8'h00);
        add_row(KIND_UNUSED, 8'hFF,   11'h7FF,  1, 1'b1, 0, 0, 0, 8'h00, 8'h00);
        add_row(KIND_PUT,    8'h00,   11'h7FF,  1, 1'b1, 1, 1, 0, 8'h00, 8'h00);
        add_row(KIND_PUT,    8'hFF,   11'd0,    1, 1'b1, 2, 2, 0, 8'h00, 8'h00);
        add_row(KIND_READ,   8'h00,   11'd0,    1, 1'b1, 2, 2, 0, 8'h00, 8'h0F);
        add_row(KIND_READ,   8'h00,   11'd1,    1, 1'b1, 2, 2, 0, 8'hFF, 8'h0F);
        // newline leaves the cursor register alone
        add_row(KIND_PUT,    NEWLINE, 11'd0,    1, 1'b1, 2, 0, 1, 8'h00, 8'h00);
        // clear keeps the cursor register, homes the position
        add_row(KIND_CLEAR,  8'h00,   11'd0,    1, 1'b1, 2, 0, 0, 8'h00, 8'h00);
        add_row(KIND_READ,   8'h00,   11'd1999, 1, 1'b1, 2, 0, 0, 8'h20, 8'h0F);
        add_row(KIND_READ,   8'h00,   11'd2000, 1, 1'b1, 2, 0, 0, 8'h00, 8'h00);
        // full row then wrap onto the next
        add_row(KIND_PUT,    8'h41,   11'd0,   80, 1'b0, 0, 0, 0, 0, 0);
        add_row(KIND_PUT,    8'h42,   11'd0,    1, 1'b0, 0, 0, 0, 0, 0);
        add_row(KIND_READ,   8'h00,   11'd80,   1, 1'b0, 0, 0, 0, 0, 0);
        // newlines past the bottom leave one scroll pending
        add_row(KIND_PUT,    NEWLINE, 11'd0,   30, 1'b0, 0, 0, 0, 0, 0);
        add_row(KIND_UNUSED, 8'h00,   11'd0,    1, 1'b0, 0, 0, 0, 0, 0);
        add_row(KIND_PUT,    8'h5A,   11'd0,    1, 1'b0, 0, 0, 0, 0, 0);
        add_row(KIND_READ,   8'h00,   11'd1920, 1, 1'b0, 0, 0, 0, 0, 0);
        add_row(KIND_READ,   8'h00,   11'd0,    1, 1'b0, 0, 0, 0, 0, 0);
        add_row(KIND_PUT,    8'h7F,   11'd0,    1, 1'b0, 0, 0, 0, 0, 0);
        add_row(KIND_READ,   8'h00,   11'd1921, 1, 1'b0, 0, 0, 0, 0, 0);

        foreach (stim_rows[k]) begin
            repeat (stim_rows[k].reps)
                send_word(stim_rows[k].kind, stim_rows[k].ch, stim_rows[k].cell_idx,
                          stim_rows[k].typed, stim_rows[k].want);
        end
        drain_results();

        // random phases under different attributes
        write_attribute(8'h00);
        run_random(180);
        drain_results();
        write_attribute(8'hFF);
        run_random(180);
        drain_results();
        write_attribute(ATTR_W'($urandom_range(0, 255)));
        run_random(180);
        drain_results();
        write_attribute(ATTR_W'($urandom_range(0, 255)));
        run_random(180);
        drain_results();

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/tccw_pkg.sv
hw/rtl/tccw_ram.sv
hw/rtl/text_console_char_writer_core.sv
hw/rtl/tccw_checker.sv
tb/tb_top.sv
